[rtl/core/sdoc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdoc_pkg
// shared widths, register indexes and the config type for the stick clamp
// ----------------------------------------------------------------------------
package sdoc_pkg;
   localparam int AXIS_W  = 8;
   localparam int MAG_W   = 8;
   localparam int REG7_W  = 7;
   localparam int NUM_W   = 22;  // diag*radius*mag, up to 127*127*128
   localparam int DEN_W   = 16;  // weighted sum d, positive when dividing
   localparam int QUO_W   = NUM_W;

   localparam logic [2:0] REG_TRIG_FLOOR = 3'd0;
   localparam logic [2:0] REG_TRIG_CEIL  = 3'd1;
   localparam logic [2:0] REG_MAIN_DEAD  = 3'd2;
   localparam logic [2:0] REG_MAIN_RAD   = 3'd3;
   localparam logic [2:0] REG_MAIN_DIAG  = 3'd4;
   localparam logic [2:0] REG_SUB_DEAD   = 3'd5;
   localparam logic [2:0] REG_SUB_RAD    = 3'd6;
   localparam logic [2:0] REG_SUB_DIAG   = 3'd7;

   typedef struct packed {
      logic [REG7_W-1:0] dead;
      logic [REG7_W-1:0] radius;
      logic [REG7_W-1:0] diag;
   } stick_cfg_type;
endpackage
`default_nettype wire

[rtl/core/sdoc_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdoc_divider
// restoring divider, one quotient bit per pipeline stage, side data rides along
// ----------------------------------------------------------------------------
module sdoc_divider
   import sdoc_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [QUO_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]      out_side
);
   localparam int REM_W = DEN_W + 1;

   logic              valid_ff [NUM_W+1];
   logic [NUM_W-1:0]  quo_ff   [NUM_W+1];
   logic [REM_W-1:0]  rem_ff   [NUM_W+1];
   logic [DEN_W-1:0]  den_ff   [NUM_W+1];
   logic [SIDE_W-1:0] side_ff  [NUM_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      quo_ff[0]  <= in_num;
      rem_ff[0]  <= '0;
      den_ff[0]  <= in_den;
      side_ff[0] <= in_side;
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [REM_W:0]    trial_in;
      logic [REM_W:0]    diff_in;
      always_comb begin
         trial_in = {rem_ff[s], quo_ff[s][NUM_W-1]};
         diff_in  = trial_in - {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (!diff_in[REM_W]) begin
            rem_ff[s+1] <= diff_in[REM_W-1:0];
            quo_ff[s+1] <= {quo_ff[s][NUM_W-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= trial_in[REM_W-1:0];
            quo_ff[s+1] <= {quo_ff[s][NUM_W-2:0], 1'b0};
         end
         den_ff[s+1]  <= den_ff[s];
         side_ff[s+1] <= side_ff[s];
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_quo   = quo_ff[NUM_W];
   assign out_side  = side_ff[NUM_W];
endmodule
`default_nettype wire

[rtl/core/sdoc_stick.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdoc_stick
// octagon clamp of one stick: fold, deadzone, weighted sum, scale, sign
// ----------------------------------------------------------------------------
module sdoc_stick
   import sdoc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic              in_conn,
   input  wire logic [AXIS_W-1:0] in_x,
   input  wire logic [AXIS_W-1:0] in_y,
   input  wire stick_cfg_type     cfg,
   output logic                   out_valid,
   output logic [AXIS_W-1:0]      out_x,
   output logic [AXIS_W-1:0]      out_y
);
   // stage 1: magnitudes after deadzone
   logic              s1_valid_ff;
   logic              s1_conn_ff, s1_negx_ff, s1_negy_ff;
   logic [AXIS_W-1:0] s1_rawx_ff, s1_rawy_ff;
   logic [MAG_W-1:0]  s1_mx_ff, s1_my_ff;
   logic [MAG_W-1:0]  absx_in, absy_in;

   always_comb begin
      absx_in = in_x[AXIS_W-1] ? (~in_x + 8'd1) : in_x;
      absy_in = in_y[AXIS_W-1] ? (~in_y + 8'd1) : in_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_conn_ff <= in_conn;
      s1_negx_ff <= in_x[AXIS_W-1];
      s1_negy_ff <= in_y[AXIS_W-1];
      s1_rawx_ff <= in_x;
      s1_rawy_ff <= in_y;
      s1_mx_ff <= (absx_in <= {1'b0, cfg.dead}) ? '0 : absx_in - {1'b0, cfg.dead};
      s1_my_ff <= (absy_in <= {1'b0, cfg.dead}) ? '0 : absy_in - {1'b0, cfg.dead};
   end

   // stage 2: products
   logic              s2_valid_ff, s2_conn_ff, s2_negx_ff, s2_negy_ff;
   logic [AXIS_W-1:0] s2_rawx_ff, s2_rawy_ff;
   logic [MAG_W-1:0]  s2_mx_ff, s2_my_ff;
   logic [14:0]       s2_wx_ff, s2_wy_ff;
   logic signed [16:0] s2_rx_ff, s2_ry_ff;   // (radius-diag)*mag
   logic [13:0]       s2_lim_ff;
   logic signed [7:0] rmd_in;

   always_comb rmd_in = $signed({1'b0, cfg.radius}) - $signed({1'b0, cfg.diag});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_conn_ff <= s1_conn_ff;
      s2_negx_ff <= s1_negx_ff;
      s2_negy_ff <= s1_negy_ff;
      s2_rawx_ff <= s1_rawx_ff;
      s2_rawy_ff <= s1_rawy_ff;
      s2_mx_ff   <= s1_mx_ff;
      s2_my_ff   <= s1_my_ff;
      s2_wx_ff   <= 15'(cfg.diag * s1_mx_ff);
      s2_wy_ff   <= 15'(cfg.diag * s1_my_ff);
      s2_rx_ff   <= 17'(rmd_in * $signed({1'b0, s1_mx_ff}));
      s2_ry_ff   <= 17'(rmd_in * $signed({1'b0, s1_my_ff}));
      s2_lim_ff  <= 14'(cfg.diag * cfg.radius);
   end

   // stage 3: weighted sum and compare
   logic              s3_valid_ff, s3_conn_ff, s3_negx_ff, s3_negy_ff, s3_scale_ff;
   logic [AXIS_W-1:0] s3_rawx_ff, s3_rawy_ff;
   logic [MAG_W-1:0]  s3_mx_ff, s3_my_ff;
   logic [13:0]       s3_lim_ff;
   logic [DEN_W-1:0]  s3_d_ff;
   logic signed [17:0] d_in;

   always_comb begin
      if (s2_wy_ff <= s2_wx_ff)
         d_in = $signed({3'b000, s2_wx_ff}) + 18'(s2_ry_ff);
      else
         d_in = $signed({3'b000, s2_wy_ff}) + 18'(s2_rx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_conn_ff  <= s2_conn_ff;
      s3_negx_ff  <= s2_negx_ff;
      s3_negy_ff  <= s2_negy_ff;
      s3_rawx_ff  <= s2_rawx_ff;
      s3_rawy_ff  <= s2_rawy_ff;
      s3_mx_ff    <= s2_mx_ff;
      s3_my_ff    <= s2_my_ff;
      s3_lim_ff   <= s2_lim_ff;
      s3_d_ff     <= d_in[DEN_W-1:0];
      s3_scale_ff <= ($signed({4'b0000, s2_lim_ff}) < d_in);
   end

   // stage 4: numerators
   localparam int SIDE_W = 1 + 1 + 1 + 1 + 2*AXIS_W + 2*MAG_W;
   logic              s4_valid_ff;
   logic [NUM_W-1:0]  s4_nx_ff, s4_ny_ff;
   logic [DEN_W-1:0]  s4_d_ff;
   logic [SIDE_W-1:0] s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_nx_ff   <= NUM_W'(s3_lim_ff * s3_mx_ff);
      s4_ny_ff   <= NUM_W'(s3_lim_ff * s3_my_ff);
      s4_d_ff    <= s3_scale_ff ? s3_d_ff : DEN_W'(1);
      s4_side_ff <= {s3_conn_ff, s3_negx_ff, s3_negy_ff, s3_scale_ff,
                     s3_rawx_ff, s3_rawy_ff, s3_mx_ff, s3_my_ff};
   end

   logic              dx_valid, dy_valid;
   logic [QUO_W-1:0]  qx, qy;
   logic [SIDE_W-1:0] side_q, side_unused;

   sdoc_divider #(.SIDE_W(SIDE_W)) u_div_x (
      .clock(clock), .reset(reset), .in_valid(s4_valid_ff), .in_num(s4_nx_ff),
      .in_den(s4_d_ff), .in_side(s4_side_ff),
      .out_valid(dx_valid), .out_quo(qx), .out_side(side_q)
   );
   sdoc_divider #(.SIDE_W(SIDE_W)) u_div_y (
      .clock(clock), .reset(reset), .in_valid(s4_valid_ff), .in_num(s4_ny_ff),
      .in_den(s4_d_ff), .in_side(s4_side_ff),
      .out_valid(dy_valid), .out_quo(qy), .out_side(side_unused)
   );

   // final stage: pick, restore sign, or pass the raw values when disconnected
   logic              f_conn, f_negx, f_negy, f_scale;
   logic [AXIS_W-1:0] f_rawx, f_rawy;
   logic [MAG_W-1:0]  f_mx, f_my, ax_in, ay_in;
   logic              out_valid_ff;
   logic [AXIS_W-1:0] out_x_ff, out_y_ff;

   always_comb begin
      {f_conn, f_negx, f_negy, f_scale, f_rawx, f_rawy, f_mx, f_my} = side_q;
      ax_in = f_scale ? qx[MAG_W-1:0] : f_mx;
      ay_in = f_scale ? qy[MAG_W-1:0] : f_my;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dx_valid & dy_valid & (side_unused == side_q);
      end
      if (!f_conn) begin
         out_x_ff <= f_rawx;
         out_y_ff <= f_rawy;
      end else begin
         out_x_ff <= f_negx ? (~ax_in + 8'd1) : ax_in;
         out_y_ff <= f_negy ? (~ay_in + 8'd1) : ay_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
endmodule
`default_nettype wire

[rtl/core/sdoc_trigger.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdoc_trigger
// trigger floor and ceiling, delayed to match the stick pipeline
// ----------------------------------------------------------------------------
module sdoc_trigger
   import sdoc_pkg::*;
#(
   parameter int DELAY = 2
) (
   input  wire logic       clock,
   input  wire logic       in_conn,
   input  wire logic [7:0] in_raw,
   input  wire logic [7:0] floor_val,
   input  wire logic [7:0] ceil_val,
   output logic [7:0]      out_val
);
   logic [7:0] capped_in, res_in;
   logic [7:0] pipe_ff [DELAY];

   always_comb begin
      capped_in = (in_raw > ceil_val) ? ceil_val : in_raw;
      if (!in_conn)
         res_in = in_raw;
      else if (in_raw <= floor_val)
         res_in = '0;
      else
         res_in = capped_in - floor_val;
   end

   always_ff @(posedge clock) begin
      pipe_ff[0] <= res_in;
      for (int i = 1; i < DELAY; i++) pipe_ff[i] <= pipe_ff[i-1];
   end

   assign out_val = pipe_ff[DELAY-1];
endmodule
`default_nettype wire

[rtl/core/stick_deadzone_octagon_clamp_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stick_deadzone_octagon_clamp_top
// deadzone, octagon clamp and trigger shaping of one controller port reading
// ----------------------------------------------------------------------------
// usage
//   raise start with a port reading on the req_ ports; the item is taken at
//   any edge where busy is low, and busy is always low, so one item a cycle
//   each item comes back on the rsp_ ports for one cycle with done high,
//   in order, through the pipeline (4 stages of fold, product, sum
//   and numerator, one divider input stage, 22 stages of one-bit restoring
//   division, one output stage)
//   latency is set by the divider stages, throughput is one item per cycle
//   csr_ writes take effect at the next edge; write only while idle
//   reset restores the register defaults and drops every item in flight
//   the receiver cannot stall: done is a strobe, results are never held
// ----------------------------------------------------------------------------
module stick_deadzone_octagon_clamp_top
   import sdoc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_connected,
   input  wire logic [7:0] req_main_x_in,
   input  wire logic [7:0] req_main_y_in,
   input  wire logic [7:0] req_sub_x_in,
   input  wire logic [7:0] req_sub_y_in,
   input  wire logic [7:0] req_left_trigger_in,
   input  wire logic [7:0] req_right_trigger_in,
   output logic            done,
   output logic [7:0]      rsp_main_x_out,
   output logic [7:0]      rsp_main_y_out,
   output logic [7:0]      rsp_sub_x_out,
   output logic [7:0]      rsp_sub_y_out,
   output logic [7:0]      rsp_left_trigger_out,
   output logic [7:0]      rsp_right_trigger_out,
   input  wire logic       csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_data
);
   // front stages, divider input register, divider stages, output register
   localparam int LATENCY = 4 + 1 + NUM_W + 1;

   // configuration registers
   logic [7:0]    floor_ff, ceil_ff;
   stick_cfg_type main_ff, sub_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= 8'd30;
         ceil_ff  <= 8'd180;
         main_ff  <= '{dead: 7'd15, radius: 7'd72, diag: 7'd40};
         sub_ff   <= '{dead: 7'd15, radius: 7'd59, diag: 7'd31};
      end else if (csr_write) begin
         case (csr_index)
            REG_TRIG_FLOOR: floor_ff <= csr_data;
            REG_TRIG_CEIL:  ceil_ff  <= csr_data;
            REG_MAIN_DEAD:  main_ff.dead   <= csr_data[6:0];
            REG_MAIN_RAD:   main_ff.radius <= csr_data[6:0];
            REG_MAIN_DIAG:  main_ff.diag   <= csr_data[6:0];
            REG_SUB_DEAD:   sub_ff.dead    <= csr_data[6:0];
            REG_SUB_RAD:    sub_ff.radius  <= csr_data[6:0];
            REG_SUB_DIAG:   sub_ff.diag    <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // the pipeline never holds items back
   assign busy = 1'b0;

   logic accept;
   logic main_valid, sub_valid;
   assign accept = start & ~busy;

   sdoc_stick u_main (
      .clock(clock), .reset(reset), .in_valid(accept), .in_conn(req_connected),
      .in_x(req_main_x_in), .in_y(req_main_y_in), .cfg(main_ff),
      .out_valid(main_valid), .out_x(rsp_main_x_out), .out_y(rsp_main_y_out)
   );

   sdoc_stick u_sub (
      .clock(clock), .reset(reset), .in_valid(accept), .in_conn(req_connected),
      .in_x(req_sub_x_in), .in_y(req_sub_y_in), .cfg(sub_ff),
      .out_valid(sub_valid), .out_x(rsp_sub_x_out), .out_y(rsp_sub_y_out)
   );

   // triggers need no division, just a matching delay line
   sdoc_trigger #(.DELAY(LATENCY)) u_left (
      .clock(clock), .in_conn(req_connected), .in_raw(req_left_trigger_in),
      .floor_val(floor_ff), .ceil_val(ceil_ff), .out_val(rsp_left_trigger_out)
   );

   sdoc_trigger #(.DELAY(LATENCY)) u_right (
      .clock(clock), .in_conn(req_connected), .in_raw(req_right_trigger_in),
      .floor_val(floor_ff), .ceil_val(ceil_ff), .out_val(rsp_right_trigger_out)
   );

   assign done = main_valid & sub_valid;
endmodule
`default_nettype wire
